FILE: rtl/ule_pkg.sv
package ule_pkg;

   localparam int unsigned LINE_LEN_DEF = 32;
   localparam int unsigned HEAD_LEN     = 8;
   localparam int unsigned HEAD_AW      = 3;
   localparam int unsigned STEP_W       = 3;

   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_BS = 8'h08;

   typedef logic [7:0] byte_type;
   typedef byte_type [HEAD_LEN-1:0] head_type;

   typedef enum logic [1:0] {
      ECHO_NONE,
      ECHO_BYTE,
      ECHO_SPACE,
      ECHO_BKSP
   } echo_kind_type;

   typedef struct packed {
      echo_kind_type kind;
      logic [7:0]    data;
      logic [3:0]    led;
   } plan_type;

   // byte k of each command sits at index k; digit slot of the single-LED forms is index 3
   localparam head_type CMD_ALL_ON  = {8'h00, 8'h00, 8'h6E, 8'h6F, 8'h20, 8'h64, 8'h65, 8'h6C};
   localparam head_type CMD_ALL_OFF = {8'h00, 8'h66, 8'h66, 8'h6F, 8'h20, 8'h64, 8'h65, 8'h6C};
   localparam head_type CMD_ONE_OFF = {8'h66, 8'h66, 8'h6F, 8'h20, 8'h30, 8'h64, 8'h65, 8'h6C};
   localparam head_type CMD_ONE_ON  = {8'h00, 8'h6E, 8'h6F, 8'h20, 8'h30, 8'h64, 8'h65, 8'h6C};

   function automatic logic prefix_match(input head_type line, input head_type cmd,
                                         input int unsigned len, input logic len_ok);
      logic ok;
      ok = len_ok;
      for (int k = 0; k < HEAD_LEN; k++) begin
         if (k < len && line[k] != cmd[k]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [STEP_W-1:0] last_step(input echo_kind_type kind);
      logic [STEP_W-1:0] s;
      case (kind)
         ECHO_SPACE: s = STEP_W'(5);
         ECHO_BKSP:  s = STEP_W'(2);
         default:    s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] echo_char(input echo_kind_type kind,
                                            input logic [STEP_W-1:0] step,
                                            input logic [7:0] data);
      logic [7:0] c;
      case (kind)
         ECHO_BYTE: c = data;
         ECHO_SPACE: begin
            case (step)
               STEP_W'(0): c = CH_SP;
               STEP_W'(1): c = 8'h73;
               STEP_W'(2): c = 8'h70;
               STEP_W'(3): c = 8'h61;
               STEP_W'(4): c = 8'h63;
               STEP_W'(5): c = 8'h65;
               default:    c = 8'h00;
            endcase
         end
         ECHO_BKSP: c = (step == STEP_W'(1)) ? CH_SP : CH_BS;
         default:   c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/ule_edit.sv
module ule_edit #(
   parameter int unsigned LINE_LEN = ule_pkg::LINE_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  logic [7:0]        rx_byte,
   input  logic              plan_take,
   output ule_pkg::plan_type plan,
   output logic              plan_valid
);
   import ule_pkg::*;

   localparam int unsigned IDX_W = $clog2(LINE_LEN + 1);
   localparam int unsigned AW    = $clog2(LINE_LEN);

   logic [IDX_W-1:0]    index_ff, index_in;
   head_type            head_ff, head_in;
   logic [LINE_LEN-1:0] space_ff, space_in;
   logic [3:0]          led_ff, led_in;
   plan_type            plan_ff, plan_in;
   logic                plan_valid_ff, plan_valid_in;

   logic             empty, full, prev_space;
   logic             len6, len7, len8;
   logic [IDX_W-1:0] index_dec;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [3:0]       cmd_led;
   head_type         one_cmd;

   assign empty     = (index_ff == '0);
   assign full      = (index_ff == IDX_W'(LINE_LEN));
   assign index_dec = index_ff - IDX_W'(1);
   assign wr_addr   = index_ff[AW-1:0];
   assign rd_addr   = index_dec[AW-1:0];
   assign prev_space = !empty && space_ff[rd_addr];
   assign len6 = (index_ff >= IDX_W'(6));
   assign len7 = (index_ff >= IDX_W'(7));
   assign len8 = (index_ff >= IDX_W'(8));

   always_comb begin
      cmd_led = led_ff;
      one_cmd = CMD_ONE_OFF;
      if (prefix_match(head_ff, CMD_ALL_ON, 6, len6)) begin
         cmd_led = 4'hF;
      end
      if (prefix_match(head_ff, CMD_ALL_OFF, 7, len7)) begin
         cmd_led = 4'h0;
      end
      for (int n = 0; n < 4; n++) begin
         one_cmd = CMD_ONE_OFF;
         one_cmd[3] = 8'h30 + 8'(n);
         if (prefix_match(head_ff, one_cmd, 8, len8)) begin
            cmd_led[n] = 1'b0;
         end
      end
      for (int n = 0; n < 4; n++) begin
         one_cmd = CMD_ONE_ON;
         one_cmd[3] = 8'h30 + 8'(n);
         if (prefix_match(head_ff, one_cmd, 7, len7)) begin
            cmd_led[n] = 1'b1;
         end
      end
   end

   always_comb begin
      index_in      = index_ff;
      head_in       = head_ff;
      space_in      = space_ff;
      led_in        = led_ff;
      plan_in       = plan_ff;
      plan_valid_in = plan_valid_ff && !plan_take;
      if (in_fire) begin
         plan_valid_in = 1'b1;
         plan_in.kind  = ECHO_NONE;
         plan_in.data  = rx_byte;
         plan_in.led   = led_ff;
         case (rx_byte)
            CH_NL: begin
               led_in      = cmd_led;
               plan_in.led = cmd_led;
               index_in    = '0;
            end
            CH_BS: begin
               if (!empty) begin
                  index_in     = index_dec;
                  plan_in.kind = ECHO_BKSP;
               end
            end
            default: begin
               if (!full && (rx_byte != CH_SP || (!empty && !prev_space))) begin
                  space_in[wr_addr] = (rx_byte == CH_SP);
                  if (index_ff < IDX_W'(HEAD_LEN)) begin
                     head_in[index_ff[HEAD_AW-1:0]] = rx_byte;
                  end
                  index_in     = index_ff + IDX_W'(1);
                  plan_in.kind = (rx_byte == CH_SP) ? ECHO_SPACE : ECHO_BYTE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         led_ff        <= 4'h0;
         plan_valid_ff <= 1'b0;
      end else begin
         index_ff      <= index_in;
         led_ff        <= led_in;
         plan_valid_ff <= plan_valid_in;
      end
      head_ff  <= head_in;
      space_ff <= space_in;
      plan_ff  <= plan_in;
   end

   assign plan       = plan_ff;
   assign plan_valid = plan_valid_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IDX_W'(LINE_LEN))
      else $error("line index beyond line length");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_fire |-> (!plan_valid_ff || plan_take))
      else $error("pending request plan overwritten");

endmodule

FILE: rtl/ule_emit.sv
module ule_emit (
   input  logic              clock,
   input  logic              reset,
   input  ule_pkg::plan_type plan,
   input  logic              plan_valid,
   output logic              plan_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_echo_valid,
   output logic [7:0]        rsp_echo_byte,
   output logic [3:0]        rsp_led_state,
   output logic              rsp_last_of_run
);
   import ule_pkg::*;

   plan_type          cur_ff, cur_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              last, done;

   assign last      = (step_ff == last_step(cur_ff.kind));
   assign done      = busy_ff && rsp_ready && last;
   assign plan_take = plan_valid && (!busy_ff || done);

   always_comb begin
      cur_in  = cur_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (plan_take) begin
         cur_in  = plan;
         step_in = '0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      cur_ff <= cur_in;
   end

   assign rsp_valid       = busy_ff;
   assign rsp_echo_valid  = (cur_ff.kind != ECHO_NONE);
   assign rsp_echo_byte   = echo_char(cur_ff.kind, step_ff, cur_ff.data);
   assign rsp_led_state   = cur_ff.led;
   assign rsp_last_of_run = last;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= last_step(cur_ff.kind))
      else $error("echo step past end of run");

   a_run_advance: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && rsp_ready && !last) |=> (busy_ff && step_ff == $past(step_ff) + STEP_W'(1)))
      else $error("echo run did not advance");

   a_silent_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_echo_valid) |-> (rsp_last_of_run && rsp_echo_byte == 8'h00))
      else $error("silent result not final");

endmodule

FILE: rtl/uart_line_editor_led_commands.sv
// Line editor for received terminal bytes with LED commands. One request carries
// one byte and is taken into a one-entry plan buffer, where the
// line state (length, first eight bytes, space marks, LED bits) is updated at once;
// a new request is taken every cycle while the buffer is free or being drained.
// Each request gives one to six results, one per cycle while rsp_ready is high:
// one for an ordinary byte, newline or ignored byte, three for a backspace and
// six for a stored space. The echo sequencer sets the sustained rate.
module uart_line_editor_led_commands #(
   parameter int unsigned LINE_LEN = ule_pkg::LINE_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_echo_valid,
   output logic [7:0] rsp_echo_byte,
   output logic [3:0] rsp_led_state,
   output logic       rsp_last_of_run
);
   import ule_pkg::*;

   plan_type plan;
   logic     plan_valid, plan_take, in_fire;

   assign req_ready = !reset && (!plan_valid || plan_take);
   assign in_fire   = req_valid && req_ready;

   ule_edit #(.LINE_LEN(LINE_LEN)) u_edit (
      .clock      (clock),
      .reset      (reset),
      .in_fire    (in_fire),
      .rx_byte    (req_rx_byte),
      .plan_take  (plan_take),
      .plan       (plan),
      .plan_valid (plan_valid)
   );

   ule_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .plan            (plan),
      .plan_valid      (plan_valid),
      .plan_take       (plan_take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_led_state   (rsp_led_state),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
